// File: hdl/ansi_text_console_engine_unit_defines.svh
// Assertion macros shared by the console engine modules.
`ifndef ANSI_TEXT_CONSOLE_ENGINE_UNIT_DEFINES_SVH
`define ANSI_TEXT_CONSOLE_ENGINE_UNIT_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define ATC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define ATC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/atc_pkg.sv
// ---------------------------------------------------------------------------
// atc_pkg
// Types, constants and command structs of the ANSI text console engine.
// ---------------------------------------------------------------------------
package atc_pkg;

  localparam int Columns = 80;
  localparam int Rows    = 25;
  localparam int Cells   = Columns * Rows;
  localparam int AddrW   = 11;
  localparam int ColW    = 7;
  localparam int RowW    = 5;

  localparam logic [1:0] REQ_PUT  = 2'd0;
  localparam logic [1:0] REQ_END  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Escape parser phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  localparam logic [7:0]  ATTR_RESET = 8'h0F;
  localparam logic [7:0]  BLANK      = 8'h20;
  localparam logic [15:0] CELL_RESET = 16'h0F20;
  localparam logic [7:0]  ESC_CODE   = 8'h1B;

  // Control and sequence bytes.
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Final bytes of escape commands.
  localparam logic [7:0] CMD_UP      = 8'h41;
  localparam logic [7:0] CMD_DOWN    = 8'h42;
  localparam logic [7:0] CMD_RIGHT   = 8'h43;
  localparam logic [7:0] CMD_LEFT    = 8'h44;
  localparam logic [7:0] CMD_POS     = 8'h48;
  localparam logic [7:0] CMD_POS_ALT = 8'h66;
  localparam logic [7:0] CMD_SAVE    = 8'h73;
  localparam logic [7:0] CMD_RESTORE = 8'h75;
  localparam logic [7:0] CMD_ERASE   = 8'h4A;
  localparam logic [7:0] CMD_ATTR    = 8'h6D;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [7:0]  cur_attribute;
    logic        in_escape;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ, ST_SCROLL, ST_FILL, ST_OUT
  } state_t;

  // Sweep kinds run by the datapath.
  typedef enum logic [1:0] {
    SW_INIT, SW_SCROLL, SW_FILL
  } sweep_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic   sweep_start;
    sweep_t sweep_kind;
    logic   exec;
    logic   read_start;
    logic   load_out;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sweep_done;
    logic need_scroll;
    logic need_fill;
  } status_t;

  function automatic logic [2:0] colour_map(input logic [2:0] i);
    logic [2:0] r;
    unique case (i)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/atc_ctrl.sv
// ---------------------------------------------------------------------------
// atc_ctrl
// Sequencer: clear sweep, accept, execute, read or scroll or fill sweep, deliver.
// ---------------------------------------------------------------------------
module atc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  atc_pkg::status_t  sts,
  output atc_pkg::cmd_t     cmd
);
  import atc_pkg::*;
  `include "ansi_text_console_engine_unit_defines.svh"

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   in_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign out_valid = ovalid_r;
  // Take a new item once the result register is free or drains now.
  assign in_ready  = (state_r == ST_IDLE) && (!ovalid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.sweep_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_xfer) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.need_scroll)    state_nxt = ST_SCROLL;
        else if (sts.need_fill) state_nxt = ST_FILL;
        else                    state_nxt = ST_READ;
      end
      ST_READ:   state_nxt = ST_OUT;
      ST_SCROLL: if (sts.sweep_done) state_nxt = ST_OUT;
      ST_FILL:   if (sts.sweep_done) state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.sweep_kind = SW_INIT;
    unique case (state_r)
      ST_IDLE: cmd.read_start = in_xfer;
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.sweep_start = sts.need_scroll || sts.need_fill;
        cmd.sweep_kind  = sts.need_scroll ? SW_SCROLL : SW_FILL;
      end
      ST_OUT:  cmd.load_out = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_ready) ovalid_nxt = 1'b0;
    if (state_r == ST_OUT) ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  `ATC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_ready, state_r == ST_IDLE)
  `ATC_ASSERT_NXT(a_accept_exec, clk, rst_n, in_xfer, state_r == ST_EXEC)
  `ATC_ASSERT_NXT(a_out_sets_valid, clk, rst_n, state_r == ST_OUT, ovalid_r)
endmodule

// File: hdl/atc_datapath.sv
// ---------------------------------------------------------------------------
// atc_datapath
// Cell store, cursor and escape parser registers, sweep engine.
// ---------------------------------------------------------------------------
module atc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  atc_pkg::in_item_t   in_item,
  input  logic                in_take,
  input  atc_pkg::cmd_t       cmd,
  output atc_pkg::status_t    sts,
  output atc_pkg::out_item_t  out_item
);
  import atc_pkg::*;
  `include "ansi_text_console_engine_unit_defines.svh"

  localparam int ScrollN = Columns * (Rows - 1);

  logic [15:0] mem [Cells];
  logic [15:0] rdata_r;

  in_item_t    item_r;
  logic [6:0]  col_r, col_nxt, scol_r, scol_nxt;
  logic [4:0]  row_r, row_nxt, srow_r, srow_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        pidx_r, pidx_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [6:0]  p1_r, p1_nxt, p2_r, p2_nxt;
  logic        scroll_c, fill_c;
  logic        wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [15:0] wr_data;

  // Sweep engine: two-step copy for scroll (read then write).
  logic        sw_busy_r, sw_half_r;
  sweep_t      sw_kind_r;
  logic [AddrW-1:0] sw_idx_r;
  logic [15:0] sw_rd_r;
  logic        sw_done;
  logic        is_read_r;
  out_item_t   out_r;

  // Execute one put or end request.
  always_comb begin
    logic [7:0] ch;
    logic [3:0] dg;
    logic [7:0] v;
    ch = item_r.char_code;
    dg = ch[3:0];
    col_nxt = col_r; row_nxt = row_r; scol_nxt = scol_r; srow_nxt = srow_r;
    attr_nxt = attr_r; phase_nxt = phase_r; pidx_nxt = pidx_r; dcnt_nxt = dcnt_r;
    p1_nxt = p1_r; p2_nxt = p2_r; scroll_c = 1'b0; fill_c = 1'b0;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0; v = '0;
    if (item_r.req_type == REQ_END) begin
      phase_nxt = PH_IDLE; pidx_nxt = 1'b0; dcnt_nxt = 2'd0;
    end else if (item_r.req_type == REQ_PUT) begin
      if (ch == ESC_CODE) begin
        phase_nxt = PH_ESC; pidx_nxt = 1'b0; dcnt_nxt = 2'd0; p1_nxt = '0; p2_nxt = '0;
      end else if (phase_r == PH_ESC) begin
        phase_nxt = (ch == CH_BRACKET) ? PH_CSI : PH_IDLE;
        pidx_nxt = 1'b0; dcnt_nxt = 2'd0;
      end else if (phase_r != PH_IDLE) begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          if (dcnt_r >= 2'd2) begin
            phase_nxt = PH_IDLE; pidx_nxt = 1'b0; dcnt_nxt = 2'd0;
          end else begin
            if (!pidx_r) p1_nxt = 7'((p1_r << 3) + (p1_r << 1) + 7'(dg));
            else         p2_nxt = 7'((p2_r << 3) + (p2_r << 1) + 7'(dg));
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end else if (ch == CH_SEMI) begin
          if (!pidx_r) begin
            pidx_nxt = 1'b1; dcnt_nxt = 2'd0;
          end else begin
            phase_nxt = PH_IDLE; pidx_nxt = 1'b0; dcnt_nxt = 2'd0;
          end
        end else begin
          phase_nxt = PH_IDLE; pidx_nxt = 1'b0; dcnt_nxt = 2'd0;
          unique case (ch)
            CMD_UP: row_nxt = (row_r > 5'(p1_r) && p1_r < 7'(Rows)) ?
                     row_r - 5'(p1_r) : '0;
            CMD_DOWN: begin
              v = 8'(row_r) + 8'(p1_r);
              row_nxt = (v >= 8'(Rows)) ? 5'(Rows - 1) : 5'(v);
            end
            CMD_RIGHT: begin
              v = 8'(col_r) + 8'(p1_r);
              col_nxt = (v >= 8'(Columns)) ? 7'(Columns - 1) : 7'(v);
            end
            CMD_LEFT: col_nxt = (col_r > p1_r) ? col_r - p1_r : '0;
            CMD_POS, CMD_POS_ALT: begin
              row_nxt = (p1_r >= 7'(Rows)) ? 5'(Rows - 1) : 5'(p1_r);
              col_nxt = (p2_r >= 7'(Columns)) ? 7'(Columns - 1) : p2_r;
            end
            CMD_SAVE: begin scol_nxt = col_r; srow_nxt = row_r; end
            CMD_RESTORE: begin col_nxt = scol_r; row_nxt = srow_r; end
            CMD_ERASE: if (p1_r == 7'd2) begin
              fill_c = 1'b1; col_nxt = '0; row_nxt = '0;
            end
            CMD_ATTR: begin
              if (p1_r == 7'd0 || p1_r == 7'd1) attr_nxt = ATTR_RESET;
              else if (p1_r == 7'd5) attr_nxt = attr_r | 8'h80;
              else if (p1_r >= 7'd30 && p1_r <= 7'd37)
                attr_nxt = {attr_r[7:4], 1'b0, colour_map(p1_r[2:0] - 3'd6)};
              else if (p1_r >= 7'd40 && p1_r <= 7'd47)
                attr_nxt = {1'b0, colour_map(p1_r[2:0]), attr_r[3:0]};
            end
            default: v = '0;
          endcase
        end
      end else if (ch == CH_LF) begin
        col_nxt = '0;
        if (row_r + 5'd1 >= 5'(Rows)) scroll_c = 1'b1;
        else row_nxt = row_r + 5'd1;
      end else if (ch == CH_CR) begin
        col_nxt = '0;
      end else if (ch == CH_BS) begin
        if (col_r != '0) col_nxt = col_r - 7'd1;
      end else begin
        wr_en = 1'b1;
        wr_addr = AddrW'(row_r) * AddrW'(Columns) + AddrW'(col_r);
        wr_data = {attr_r, ch};
        if (col_r + 7'd1 >= 7'(Columns)) begin
          col_nxt = '0;
          if (row_r + 5'd1 >= 5'(Rows)) scroll_c = 1'b1;
          else row_nxt = row_r + 5'd1;
        end else col_nxt = col_r + 7'd1;
      end
    end
  end

  assign sts.need_scroll = scroll_c;
  assign sts.need_fill   = fill_c;
  assign sw_done = sw_busy_r &&
    ((sw_kind_r == SW_SCROLL) ? (sw_idx_r == AddrW'(Cells - 1) && sw_half_r)
                              : (sw_idx_r == AddrW'(Cells - 1)));
  assign sts.sweep_done = sw_done;

  // Register state, run sweeps and the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; scol_r <= '0; srow_r <= '0; attr_r <= ATTR_RESET;
      phase_r <= PH_IDLE; pidx_r <= 1'b0; dcnt_r <= '0; p1_r <= '0; p2_r <= '0;
      sw_busy_r <= 1'b1; sw_kind_r <= SW_INIT; sw_idx_r <= '0; sw_half_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        col_r <= col_nxt; row_r <= row_nxt; scol_r <= scol_nxt; srow_r <= srow_nxt;
        attr_r <= attr_nxt; phase_r <= phase_nxt; pidx_r <= pidx_nxt;
        dcnt_r <= dcnt_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt;
      end
      if (cmd.sweep_start) begin
        sw_busy_r <= 1'b1; sw_kind_r <= cmd.sweep_kind; sw_half_r <= 1'b0;
        sw_idx_r  <= '0;
      end else if (sw_busy_r) begin
        if (sw_kind_r == SW_SCROLL && !sw_half_r) sw_half_r <= 1'b1;
        else begin
          sw_half_r <= 1'b0;
          if (sw_done) sw_busy_r <= 1'b0;
          else sw_idx_r <= sw_idx_r + AddrW'(1);
        end
      end
    end
  end

  // Cell store: one write port, two registered read ports (sweep copy and request read).
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= wr_data;
    else if (sw_busy_r) begin
      if (sw_kind_r == SW_INIT) mem[sw_idx_r] <= CELL_RESET;
      else if (sw_kind_r == SW_FILL) mem[sw_idx_r] <= {attr_r, BLANK};
      else if (sw_half_r)
        mem[sw_idx_r] <= (sw_idx_r < AddrW'(ScrollN)) ? sw_rd_r : {attr_r, BLANK};
    end
    if (sw_busy_r && !sw_half_r && sw_idx_r < AddrW'(ScrollN))
      sw_rd_r <= mem[sw_idx_r + AddrW'(Columns)];
    if (cmd.read_start)
      rdata_r <= (in_item.cell_addr < AddrW'(Cells)) ? mem[in_item.cell_addr] : '0;
  end

  // Hold the request, then build the result.
  always_ff @(posedge clk) begin
    if (in_take) item_r <= in_item;
    if (cmd.read_start) is_read_r <= (in_item.req_type == REQ_READ);
    if (cmd.load_out) begin
      out_r.cell_data     <= is_read_r ? rdata_r : '0;
      out_r.cursor_col    <= col_r;
      out_r.cursor_row    <= row_r;
      out_r.cur_attribute <= attr_r;
      out_r.in_escape     <= (phase_r != PH_IDLE);
    end
  end
  assign out_item = out_r;

  `ATC_ASSERT_IMP(a_col_range, clk, rst_n, 1'b1, col_r < 7'(Columns))
  `ATC_ASSERT_IMP(a_row_range, clk, rst_n, 1'b1, row_r < 5'(Rows))
  `ATC_ASSERT_IMP(a_no_start_busy, clk, rst_n, cmd.sweep_start, !sw_busy_r)
endmodule

// File: hdl/ansi_text_console_engine_unit.sv
// ---------------------------------------------------------------------------
// ansi_text_console_engine_unit
// ANSI escape text console over an 80x25 cell store.
// ---------------------------------------------------------------------------
// channel | ports                          | direction
// in      | in_valid in_ready in_data      | item in
// out     | out_valid out_ready out_data   | result out
//
// Steps per request: accept, execute, read, load result.
// Scroll replaces the read step with a copy sweep (a read and a write per cell),
// clear with a fill sweep.
// Reset: a sweep writes 0x0F20 to every cell; no input taken.
// Out stalls hold the result register; the next item is taken on drain.
module ansi_text_console_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  atc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output atc_pkg::out_item_t  out_data
);
  import atc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  atc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  atc_datapath u_dp (
    .clk, .rst_n, .in_item(in_data), .in_take(in_valid && in_ready),
    .cmd, .sts, .out_item(out_data)
  );
endmodule
